FILE: rtl/ssjd_pkg.sv
// ----------------------------------------------------------------------------
// ssjd_pkg - shared types and constants for the shot sequencer
// Field widths, sequencer state codes, lever codes, register indexes and
// register reset values.
// ----------------------------------------------------------------------------
package ssjd_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int ENC_W     = 32;
  localparam int LEVER_W   = 2;
  localparam int HEAT_W    = 16;
  localparam int STATE_W   = 3;
  localparam int REF_W     = 34;
  localparam int COUNT_W   = 20;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  // Sequencer states
  localparam logic [STATE_W-1:0] ST_CLOSED  = 3'd0;
  localparam logic [STATE_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STATE_W-1:0] ST_READY   = 3'd2;
  localparam logic [STATE_W-1:0] ST_SINGLE  = 3'd3;
  localparam logic [STATE_W-1:0] ST_JAMMED  = 3'd4;
  localparam logic [STATE_W-1:0] ST_BACKOFF = 3'd5;
  localparam logic [STATE_W-1:0] ST_FAILED  = 3'd6;

  // Lever positions
  localparam logic [LEVER_W-1:0] LEVER_UP   = 2'd0;
  localparam logic [LEVER_W-1:0] LEVER_MID  = 2'd1;
  localparam logic [LEVER_W-1:0] LEVER_DOWN = 2'd2;
  localparam logic [LEVER_W-1:0] LEVER_NONE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHOT_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DONE_ERROR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOT_TMO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_INTVL  = 3'd4;

  // Register reset values
  localparam logic [COUNT_W-1:0] RST_SHOT_STEP  = 20'd49152;
  localparam logic [COUNT_W-1:0] RST_DONE_ERROR = 20'd5000;
  localparam logic [MS_W-1:0]    RST_SHOT_TMO   = 16'd1000;
  localparam logic [MS_W-1:0]    RST_HEAT_LIMIT = 16'd100;
  localparam logic [MS_W-1:0]    RST_AUTO_INTVL = 16'd500;

endpackage

FILE: rtl/ssjd_tick_if.sv
// ----------------------------------------------------------------------------
// ssjd_tick_if - control tick channel
// One transaction carries one control tick into the sequencer.
// ----------------------------------------------------------------------------
interface ssjd_tick_if import ssjd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         now_ms;
  logic signed [ENC_W-1:0]   encoder_total;
  logic [LEVER_W-1:0]        lever_position;
  logic                      mouse_click;
  logic                      gimbal_relaxed;
  logic                      auto_aim;
  logic                      auto_fire_request;
  logic [HEAT_W-1:0]         barrel_heat;

  modport source (
    output valid, now_ms, encoder_total, lever_position, mouse_click,
           gimbal_relaxed, auto_aim, auto_fire_request, barrel_heat,
    input  ready
  );
  modport sink (
    input  valid, now_ms, encoder_total, lever_position, mouse_click,
           gimbal_relaxed, auto_aim, auto_fire_request, barrel_heat,
    output ready
  );
endinterface

FILE: rtl/ssjd_result_if.sv
// ----------------------------------------------------------------------------
// ssjd_result_if - sequencer result channel
// One transaction carries the state, firing flag and angle reference.
// ----------------------------------------------------------------------------
interface ssjd_result_if import ssjd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATE_W-1:0]        shot_state;
  logic                      firing_enabled;
  logic signed [REF_W-1:0]   angle_reference;

  modport source (
    output valid, shot_state, firing_enabled, angle_reference,
    input  ready
  );
  modport sink (
    input  valid, shot_state, firing_enabled, angle_reference,
    output ready
  );
endinterface

FILE: rtl/ssjd_cfg_if.sv
// ----------------------------------------------------------------------------
// ssjd_cfg_if - configuration write channel
// One transaction writes one register, selected by index.
// ----------------------------------------------------------------------------
interface ssjd_cfg_if import ssjd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/shot_sequencer_jam_detect.sv
// ----------------------------------------------------------------------------
// shot_sequencer_jam_detect - trigger shot sequencer with jam detection
// Per-tick fire mode selection, shot arming and jam judgement.
// ----------------------------------------------------------------------------
// Every tick transaction yields exactly one result transaction. A tick sits
// in an input register, and the whole update (lever edges, shot arming,
// error and timeout judgement) runs as one combinational pass into the
// sequencer state and the result register, so the result register is
// loaded from the input register once the result register is free, and a
// new tick is taken every cycle unless the block stalls. Throughput is one
// tick per clock while not stalled; the block only stalls when the result
// register is full and not being taken. Configuration writes are always
// accepted (cfg.ready tied high) and must only happen while no tick is in
// flight. Register writes with an index past the last register are dropped.
// Error magnitudes are exact integers; time differences wrap modulo 2^32.
// ----------------------------------------------------------------------------
module shot_sequencer_jam_detect import ssjd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ssjd_tick_if.sink   tick,
  ssjd_cfg_if.sink    cfg,
  ssjd_result_if.source result
);

  // Configuration registers
  logic [COUNT_W-1:0] shot_step;
  logic [COUNT_W-1:0] done_error;
  logic [MS_W-1:0]    shot_tmo;
  logic [MS_W-1:0]    heat_limit;
  logic [MS_W-1:0]    auto_intvl;

  // Input register
  logic                    s1_valid;
  logic [TIME_W-1:0]       s1_now;
  logic signed [ENC_W-1:0] s1_enc;
  logic [LEVER_W-1:0]      s1_lever;
  logic                    s1_click;
  logic                    s1_relaxed;
  logic                    s1_auto;
  logic                    s1_autoreq;
  logic [HEAT_W-1:0]       s1_heat;

  // Sequencer state
  logic                    fire_toggle;
  logic                    fire_on;
  logic [STATE_W-1:0]      seq_state;
  logic [LEVER_W-1:0]      prev_lever;
  logic signed [REF_W-1:0] target_pos;
  logic [TIME_W-1:0]       shot_start;
  logic [TIME_W-1:0]       last_auto;

  // Result register
  logic                    out_valid;
  logic [STATE_W-1:0]      res_state;
  logic                    res_fire;
  logic signed [REF_W-1:0] res_angle;

  // Handshake: result register frees up when empty or being taken
  logic advance;
  logic step_en;

  assign advance    = !out_valid || result.ready;
  assign step_en    = s1_valid && advance;
  assign tick.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  assign result.valid           = out_valid;
  assign result.shot_state      = res_state;
  assign result.firing_enabled  = res_fire;
  assign result.angle_reference = res_angle;

  // ---------------------------------------------------------------------------
  // Tick update
  // ---------------------------------------------------------------------------
  logic                    up_edge;
  logic                    down_edge;
  logic                    fon;
  logic [STATE_W-1:0]      st_mode;
  logic                    auto_path;
  logic                    auto_fire;
  logic                    man_fire;
  logic                    fire;
  logic [STATE_W-1:0]      st_shot;
  logic [STATE_W-1:0]      st_jam;
  logic signed [REF_W-1:0] enc_ext;
  logic signed [REF_W-1:0] step_ext;
  logic signed [REF_W:0]   diff_old;
  logic [REF_W:0]          abs_old;
  logic [REF_W-1:0]        err;
  logic [TIME_W-1:0]       elapsed;
  logic [TIME_W-1:0]       auto_gap;
  logic                    big;
  logic                    early;
  logic                    late;

  logic                    fire_toggle_next;
  logic                    fire_on_next;
  logic [STATE_W-1:0]      seq_state_next;
  logic signed [REF_W-1:0] target_pos_next;

  assign up_edge   = (prev_lever != LEVER_UP)   && (s1_lever == LEVER_UP);
  assign down_edge = (prev_lever != LEVER_DOWN) && (s1_lever == LEVER_DOWN);

  // Fire request as seen this tick when not relaxed
  assign fon = fire_toggle ^ up_edge;

  assign enc_ext  = REF_W'(s1_enc);
  assign step_ext = signed'({{(REF_W-COUNT_W){1'b0}}, shot_step});

  // Mode selection
  always_comb begin
    if (!fon) begin
      st_mode = ST_CLOSED;
    end else if ((down_edge || s1_click) && seq_state == ST_DONE) begin
      st_mode = ST_READY;
    end else if (seq_state == ST_JAMMED || seq_state == ST_BACKOFF ||
                 seq_state == ST_FAILED || seq_state == ST_SINGLE) begin
      st_mode = seq_state;
    end else begin
      st_mode = ST_DONE;
    end
  end

  // Shot arming; an auto request in auto mode displaces a manual shot
  assign auto_gap  = s1_now - last_auto;
  assign auto_path = s1_autoreq && s1_auto;
  assign auto_fire = auto_path && (s1_heat < heat_limit) &&
                     (auto_gap > TIME_W'(auto_intvl));
  assign man_fire  = !auto_path && (st_mode == ST_READY);
  assign fire      = fon && (auto_fire || man_fire);
  assign st_shot   = fire ? ST_SINGLE : st_mode;

  // A fresh shot leaves exactly one step of error and zero elapsed time,
  // so only the held reference needs the full subtract.
  assign diff_old = (REF_W+1)'(target_pos) - (REF_W+1)'(enc_ext);
  assign abs_old  = diff_old[REF_W] ? (REF_W+1)'(-diff_old) : unsigned'(diff_old);
  assign err      = fire ? REF_W'(shot_step) : abs_old[REF_W-1:0];
  assign elapsed  = fire ? '0 : (s1_now - shot_start);

  assign big   = err > REF_W'(done_error);
  assign early = elapsed < TIME_W'(shot_tmo);
  assign late  = elapsed > TIME_W'(shot_tmo);

  assign st_jam = (big && late && st_shot == ST_SINGLE) ? ST_JAMMED : st_shot;

  always_comb begin
    fire_toggle_next = fire_toggle;
    fire_on_next     = 1'b0;
    seq_state_next   = ST_CLOSED;
    target_pos_next  = enc_ext;
    if (!s1_relaxed) begin
      fire_toggle_next = fon;
      fire_on_next     = fon;
      if (fon) begin
        if (fire) begin
          target_pos_next = auto_path ? (enc_ext - step_ext) : (enc_ext + step_ext);
        end else begin
          target_pos_next = target_pos;
        end
      end
      // Jam judgement, skipped while closed
      if (st_shot == ST_CLOSED) begin
        seq_state_next = ST_CLOSED;
      end else if (big && early && st_jam == ST_BACKOFF) begin
        seq_state_next = st_jam;
      end else if (big && late && st_jam == ST_BACKOFF) begin
        seq_state_next = ST_FAILED;
      end else if (err < REF_W'(done_error)) begin
        seq_state_next = ST_DONE;
      end else begin
        seq_state_next = st_jam;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      shot_step  <= RST_SHOT_STEP;
      done_error <= RST_DONE_ERROR;
      shot_tmo   <= RST_SHOT_TMO;
      heat_limit <= RST_HEAT_LIMIT;
      auto_intvl <= RST_AUTO_INTVL;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_SHOT_STEP:  shot_step  <= cfg.data;
        CFG_DONE_ERROR: done_error <= cfg.data;
        CFG_SHOT_TMO:   shot_tmo   <= cfg.data[MS_W-1:0];
        CFG_HEAT_LIMIT: heat_limit <= cfg.data[MS_W-1:0];
        CFG_AUTO_INTVL: auto_intvl <= cfg.data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (step_en) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_now     <= tick.now_ms;
      s1_enc     <= tick.encoder_total;
      s1_lever   <= tick.lever_position;
      s1_click   <= tick.mouse_click;
      s1_relaxed <= tick.gimbal_relaxed;
      s1_auto    <= tick.auto_aim;
      s1_autoreq <= tick.auto_fire_request;
      s1_heat    <= tick.barrel_heat;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_toggle <= 1'b0;
      fire_on     <= 1'b0;
      seq_state   <= ST_CLOSED;
      prev_lever  <= LEVER_NONE;
      target_pos  <= '0;
      shot_start  <= '0;
      last_auto   <= '0;
    end else if (step_en) begin
      fire_toggle <= fire_toggle_next;
      fire_on     <= fire_on_next;
      seq_state   <= seq_state_next;
      prev_lever  <= s1_lever;
      target_pos  <= target_pos_next;
      if (!s1_relaxed && fire) begin
        shot_start <= s1_now;
      end
      if (!s1_relaxed && fon && auto_fire) begin
        last_auto <= s1_now;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_state <= seq_state_next;
      res_fire  <= fire_on_next;
      res_angle <= target_pos_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Backing off and failed are never entered
  a_no_backoff: assert property (@(posedge clk) disable iff (rst)
    seq_state != ST_BACKOFF && seq_state != ST_FAILED)
    else $error("sequencer entered an unreachable state");

  // With firing off the sequencer is always closed
  a_closed_when_off: assert property (@(posedge clk) disable iff (rst)
    !fire_on |-> seq_state == ST_CLOSED)
    else $error("sequencer open while firing is off");

  // A relaxed tick makes the reference track the encoder
  a_relax_tracks: assert property (@(posedge clk) disable iff (rst)
    step_en && s1_relaxed |=> res_angle == $past(enc_ext) && res_state == ST_CLOSED)
    else $error("relaxed tick did not close and track encoder");

  // An accepted tick always lands in the input register
  a_tick_held: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> s1_valid)
    else $error("accepted tick lost");

endmodule

FILE: bench/shot_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shot_check_pkg - tick/result types and scoreboard for the shot sequencer
// Holds a cycle-free model of the sequencer that turns each accepted tick
// into the expected state, firing flag and angle reference, and checks
// results against them in order.
// ----------------------------------------------------------------------------
package shot_check_pkg;
  import ssjd_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0]       now_ms;
    logic signed [ENC_W-1:0] encoder_total;
    logic [LEVER_W-1:0]      lever_position;
    logic                    mouse_click;
    logic                    gimbal_relaxed;
    logic                    auto_aim;
    logic                    auto_fire_request;
    logic [HEAT_W-1:0]       barrel_heat;
  } tick_t;

  typedef struct packed {
    logic [STATE_W-1:0]      shot_state;
    logic                    firing_enabled;
    logic signed [REF_W-1:0] angle_reference;
  } seq_result_t;

  localparam int REPORT_LIMIT = 10;

  class shot_scoreboard;
    // registers
    logic [COUNT_W-1:0] step_cnt;
    logic [COUNT_W-1:0] done_err;
    logic [MS_W-1:0]    tmo_ms;
    logic [MS_W-1:0]    heat_lim;
    logic [MS_W-1:0]    intvl_ms;
    // sequencer state
    bit                 toggle_q;
    bit                 fire_q;
    logic [STATE_W-1:0] state_q;
    logic [LEVER_W-1:0] prev_lever_q;
    longint             target_pos;
    logic [TIME_W-1:0]  shot_start;
    logic [TIME_W-1:0]  last_auto;

    seq_result_t        expected_refs[$];
    int                 mismatches;
    int                 checked;
    int                 shots;
    int                 jams;

    function new();
      step_cnt     = RST_SHOT_STEP;
      done_err     = RST_DONE_ERROR;
      tmo_ms       = RST_SHOT_TMO;
      heat_lim     = RST_HEAT_LIMIT;
      intvl_ms     = RST_AUTO_INTVL;
      toggle_q     = 1'b0;
      fire_q       = 1'b0;
      state_q      = ST_CLOSED;
      prev_lever_q = LEVER_NONE;
      target_pos   = 0;
      shot_start   = '0;
      last_auto    = '0;
      mismatches   = 0;
      checked      = 0;
      shots        = 0;
      jams         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_SHOT_STEP:  step_cnt = val;
        CFG_DONE_ERROR: done_err = val;
        CFG_SHOT_TMO:   tmo_ms   = val[MS_W-1:0];
        CFG_HEAT_LIMIT: heat_lim = val[MS_W-1:0];
        CFG_AUTO_INTVL: intvl_ms = val[MS_W-1:0];
        default: ;   // unused indexes are dropped
      endcase
    endfunction

    function int pending();
      return expected_refs.size();
    endfunction

    // One control tick: mode selection, shot arming, then jam judgement.
    function void advance_sequencer(tick_t t);
      bit                up_edge, down_edge;
      bit                big, early, late;
      longint            enc, step_l, done_l, diff, err;
      logic [TIME_W-1:0] elapsed, since_auto;
      seq_result_t       r;

      enc       = longint'(t.encoder_total);
      step_l    = longint'(step_cnt);
      done_l    = longint'(done_err);
      up_edge   = prev_lever_q != LEVER_UP && t.lever_position == LEVER_UP;
      down_edge = prev_lever_q != LEVER_DOWN && t.lever_position == LEVER_DOWN;

      if (up_edge && !t.gimbal_relaxed) toggle_q = !toggle_q;
      if (!t.gimbal_relaxed) fire_q = toggle_q;
      if (fire_q) begin
        if ((down_edge || t.mouse_click) && state_q == ST_DONE) begin
          state_q = ST_READY;
        end else if (state_q != ST_JAMMED && state_q != ST_BACKOFF &&
                     state_q != ST_FAILED && state_q != ST_SINGLE) begin
          state_q = ST_DONE;
        end
      end else begin
        state_q = ST_CLOSED;
      end
      prev_lever_q = t.lever_position;

      if (t.gimbal_relaxed) begin
        fire_q     = 1'b0;
        state_q    = ST_CLOSED;
        target_pos = enc;
      end else begin
        if (fire_q) begin
          // auto request in auto mode wins over a pending manual shot
          if (t.auto_fire_request && t.auto_aim) begin
            since_auto = t.now_ms - last_auto;
            if (t.barrel_heat < heat_lim && since_auto > intvl_ms) begin
              last_auto  = t.now_ms;
              shot_start = t.now_ms;
              target_pos = enc - step_l;
              state_q    = ST_SINGLE;
              shots++;
            end
          end else if (state_q == ST_READY) begin
            shot_start = t.now_ms;
            target_pos = enc + step_l;
            state_q    = ST_SINGLE;
            shots++;
          end
        end else begin
          target_pos = enc;
        end

        elapsed = t.now_ms - shot_start;
        diff    = target_pos - enc;
        err     = (diff < 0) ? -diff : diff;
        big     = err > done_l;
        early   = elapsed < tmo_ms;
        late    = elapsed > tmo_ms;
        if (state_q != ST_CLOSED) begin
          if (big && late && state_q == ST_SINGLE) begin
            state_q = ST_JAMMED;
            jams++;
          end
          if (!(big && early && state_q == ST_BACKOFF)) begin
            if (big && late && state_q == ST_BACKOFF) state_q = ST_FAILED;
            else if (err < done_l) state_q = ST_DONE;
          end
        end
      end

      r.shot_state      = state_q;
      r.firing_enabled  = fire_q;
      r.angle_reference = target_pos[REF_W-1:0];
      expected_refs.push_back(r);
    endfunction

    function void flag_error(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", what);
    endfunction

    function void check_result(seq_result_t got);
      seq_result_t want;
      checked++;
      if (expected_refs.size() == 0) begin
        flag_error($sformatf("result %0d with nothing pending: state %0d fire %0d ref %0d",
                             checked, got.shot_state, got.firing_enabled,
                             got.angle_reference));
        return;
      end
      want = expected_refs.pop_front();
      if (got.shot_state !== want.shot_state ||
          got.firing_enabled !== want.firing_enabled ||
          got.angle_reference !== want.angle_reference) begin
        flag_error($sformatf({"result %0d: expected state %0d fire %0d ref %0d,",
                              " got state %0d fire %0d ref %0d"},
                             checked, want.shot_state, want.firing_enabled,
                             want.angle_reference, got.shot_state,
                             got.firing_enabled, got.angle_reference));
      end
    endfunction
  endclass

endpackage

FILE: bench/tb_shot_sequencer_jam_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shot_sequencer_jam_detect - self-checking bench for the shot sequencer
// Drives control ticks and register writes, predicts every result with the
// scoreboard model and compares state, firing flag and angle reference in
// order. Runs a directed opener, then random ticks under five register
// settings with varying source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_shot_sequencer_jam_detect;
  import ssjd_pkg::*;
  import shot_check_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES   = 4;     // idle wait before register writes and the final report
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk;
  logic rst;

  ssjd_tick_if   tick();
  ssjd_cfg_if    cfg();
  ssjd_result_if result();

  shot_sequencer_jam_detect dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .cfg    (cfg),
    .result (result)
  );

  shot_scoreboard sb;

  int                 send_idle_pct;   // chance of a source gap per cycle
  int                 recv_stall_pct;  // chance of sink back-pressure per cycle
  int                 ticks_sent;
  int                 settings_used;
  int                 idle_cycles;
  logic [TIME_W-1:0]  clock_ms;        // running time stamp for random ticks
  logic [ENC_W-1:0]   enc_cur;         // running encoder value
  logic [LEVER_W-1:0] lever_cur;

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result sink: sample the transaction of this edge, then pick next ready.
  initial begin
    seq_result_t got;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        got.shot_state      = result.shot_state;
        got.firing_enabled  = result.firing_enabled;
        got.angle_reference = result.angle_reference;
        sb.check_result(got);
      end
      result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (tick.valid && tick.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
    $display("shot_sequencer_jam_detect: mismatch");
    $finish;
  end

  function automatic tick_t make_tick(logic [TIME_W-1:0] now, logic [ENC_W-1:0] enc,
                                      logic [LEVER_W-1:0] lever, bit click, bit relaxed,
                                      bit autom, bit autoreq, logic [HEAT_W-1:0] heat);
    tick_t t;
    t.now_ms            = now;
    t.encoder_total     = enc;
    t.lever_position    = lever;
    t.mouse_click       = click;
    t.gimbal_relaxed    = relaxed;
    t.auto_aim          = autom;
    t.auto_fire_request = autoreq;
    t.barrel_heat       = heat;
    return t;
  endfunction

  // Random source gaps first, then hold the tick until it is taken. valid is
  // left high on return so back-to-back ticks never drop it.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid             <= 1'b1;
    tick.now_ms            <= t.now_ms;
    tick.encoder_total     <= t.encoder_total;
    tick.lever_position    <= t.lever_position;
    tick.mouse_click       <= t.mouse_click;
    tick.gimbal_relaxed    <= t.gimbal_relaxed;
    tick.auto_aim          <= t.auto_aim;
    tick.auto_fire_request <= t.auto_fire_request;
    tick.barrel_heat       <= t.barrel_heat;
    do @(posedge clk); while (!tick.ready);
    sb.advance_sequencer(t);
    ticks_sent++;
  endtask

  // Stop sending and wait for every predicted result. Always waits on the
  // clock before checking, so valid is never driven twice in one step.
  task automatic wait_drained();
    tick.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
  endtask

  // Registers only change with the pipeline empty.
  task automatic program_regs(input logic [CFG_DAT_W-1:0] step, done, tmo, heat, intvl);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_SHOT_STEP, step);
    write_reg(CFG_DONE_ERROR, done);
    write_reg(CFG_SHOT_TMO, tmo);
    write_reg(CFG_HEAT_LIMIT, heat);
    write_reg(CFG_AUTO_INTVL, intvl);
    write_reg(CFG_UNUSED, CFG_DAT_W'($urandom));   // must be ignored
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  // Opener under reset register values. Time starts just below the 32-bit
  // wrap so the first shot's timeout is judged across it.
  task automatic run_directed();
    logic [TIME_W-1:0] t0, base;
    t0 = 32'hFFFF_FE00;
    // firing off: reference follows the encoder (most positive count)
    send_tick(make_tick(t0, 32'h7FFF_FFFF, LEVER_MID, 0, 0, 0, 0, 16'h0000));
    // up edge turns firing on, closed goes to done
    send_tick(make_tick(t0 + 1, 32'h7FFF_FFFF, LEVER_UP, 0, 0, 0, 0, 16'h0000));
    // down edge arms a manual shot from the most negative count
    send_tick(make_tick(t0 + 2, 32'h8000_0000, LEVER_DOWN, 0, 0, 0, 0, 16'h0000));
    base = sb.shot_start;
    // elapsed equal to timeout (across the wrap) holds single
    send_tick(make_tick(base + sb.tmo_ms, 32'h8000_0000, LEVER_DOWN, 0, 0, 0, 0, 16'h0000));
    // one past timeout with the trigger stuck: jam
    send_tick(make_tick(base + sb.tmo_ms + 1, 32'h8000_0000, LEVER_DOWN, 0, 0, 0, 0, 0));
    // error exactly at threshold leaves the jam in place
    send_tick(make_tick(base + sb.tmo_ms + 2, ENC_W'(sb.target_pos - sb.done_err), LEVER_DOWN,
                        0, 0, 0, 0, 16'h0000));
    // one below threshold: jam recovers to done
    send_tick(make_tick(base + sb.tmo_ms + 3, ENC_W'(sb.target_pos + sb.done_err - 1),
                        LEVER_DOWN, 0, 0, 0, 0, 16'h0000));
    // mouse click arms the next manual shot
    send_tick(make_tick(base + 1100, 32'h0000_0000, LEVER_MID, 1, 0, 0, 0, 16'h0000));
    send_tick(make_tick(base + 1101, ENC_W'(sb.target_pos - sb.done_err + 1), LEVER_MID,
                        0, 0, 0, 0, 16'h0000));
    // auto shot steps back past the 32-bit range of the encoder
    send_tick(make_tick(32'd600, 32'h8000_0000, LEVER_MID, 0, 0, 1, 1, 16'd99));
    // unreachable target: jams once the timeout is exceeded
    send_tick(make_tick(32'd1601, 32'h8000_0000, LEVER_MID, 0, 0, 0, 0, 16'h0000));
    // heat equal to the limit blocks auto fire
    send_tick(make_tick(32'd1700, 32'h0000_0000, LEVER_MID, 0, 0, 1, 1, 16'd100));
    // gap equal to the auto interval blocks auto fire
    send_tick(make_tick(32'd1100, 32'h0000_0000, LEVER_MID, 0, 0, 1, 1, 16'h0000));
    // one more ms: auto shot restarts out of the jam
    send_tick(make_tick(32'd1101, 32'h0000_0000, LEVER_MID, 0, 0, 1, 1, 16'h0000));
    send_tick(make_tick(32'd1102, ENC_W'(sb.target_pos), LEVER_MID, 0, 0, 0, 0, 16'h0000));
    // blocked auto request still swallows the click
    send_tick(make_tick(32'd1103, ENC_W'(sb.target_pos), LEVER_MID, 1, 0, 1, 1, 16'hFFFF));
    // relax: up edge ignored, closed, reference tracks encoder
    send_tick(make_tick(32'd1104, 32'h1234_5678, LEVER_UP, 0, 1, 0, 0, 16'h0000));
    // lever already up, no edge; firing comes back from the kept toggle
    send_tick(make_tick(32'd1105, 32'h1234_5678, LEVER_UP, 0, 0, 0, 0, 16'h0000));
    send_tick(make_tick(32'd1106, 32'h1234_5678, LEVER_MID, 0, 0, 0, 0, 16'h0000));
    // second up edge turns firing off
    send_tick(make_tick(32'd1107, 32'hEDCB_A987, LEVER_UP, 0, 0, 0, 0, 16'h0000));
    // no-position lever with a click while off
    send_tick(make_tick(32'd1108, 32'hEDCB_A987, LEVER_NONE, 1, 0, 0, 0, 16'h0000));
    send_tick(make_tick(32'd1109, 32'hEDCB_A987, LEVER_DOWN, 0, 0, 0, 0, 16'h0000));
    send_tick(make_tick(32'd1110, 32'hFFFF_FFFF, LEVER_UP, 0, 0, 0, 0, 16'h0000));
    // auto request outside auto mode: manual shot goes ahead
    send_tick(make_tick(32'd1111, 32'hFFFF_FFFF, LEVER_DOWN, 0, 0, 0, 1, 16'h0000));
    // relax in the middle of a shot
    send_tick(make_tick(32'd1112, 32'h0000_0001, LEVER_DOWN, 0, 1, 1, 1, 16'h0000));
  endtask

  // Random ticks. Encoder most often follows the predicted reference (finished
  // shots), often sticks (jams), sometimes jumps anywhere. Time stamps are
  // steered onto the timeout and interval boundaries now and then.
  task automatic random_ticks(input int count);
    tick_t  t;
    int     n, pick, dmax;
    longint off;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)       clock_ms = $urandom;
      else if (pick < 13) clock_ms = sb.shot_start + sb.tmo_ms + $urandom_range(0, 2) - 1;
      else if (pick < 18) clock_ms = sb.last_auto + sb.intvl_ms + $urandom_range(0, 1);
      else if (pick < 22) clock_ms = clock_ms + $urandom_range(500, 3000);
      else                clock_ms = clock_ms + $urandom_range(0, 40);

      dmax = sb.done_err + 2;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        off     = longint'($urandom_range(0, 2 * dmax));
        enc_cur = ENC_W'(sb.target_pos + off - dmax);
      end else if (pick < 45) begin
        // error right at the finish threshold
        off = longint'(sb.done_err);
        off = off + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) off = -off;
        enc_cur = ENC_W'(sb.target_pos + off);
      end else if (pick < 70) begin
        enc_cur = enc_cur;   // trigger stuck
      end else if (pick < 90) begin
        off     = longint'($urandom_range(0, 6000));
        enc_cur = ENC_W'(enc_cur + off - 3000);
      end else begin
        enc_cur = $urandom;
      end

      if ($urandom_range(0, 99) < 30) lever_cur = LEVER_W'($urandom_range(0, 3));

      t.now_ms            = clock_ms;
      t.encoder_total     = enc_cur;
      t.lever_position    = lever_cur;
      t.mouse_click       = ($urandom_range(0, 99) < 15);
      t.gimbal_relaxed    = ($urandom_range(0, 99) < 7);
      t.auto_aim          = ($urandom_range(0, 99) < 50);
      t.auto_fire_request = ($urandom_range(0, 99) < 30);
      if ($urandom_range(0, 99) < 60) begin
        t.barrel_heat = HEAT_W'($urandom_range(0, 2 * sb.heat_lim + 1));
      end else begin
        t.barrel_heat = HEAT_W'($urandom);
      end
      send_tick(t);

      // hold off now and then until the pipeline is empty
      if (n == count / 2 || $urandom_range(0, 299) == 0) wait_drained();
    end
  endtask

  initial begin
    rst                    <= 1'b1;
    tick.valid             <= 1'b0;
    tick.now_ms            <= '0;
    tick.encoder_total     <= '0;
    tick.lever_position    <= LEVER_NONE;
    tick.mouse_click       <= 1'b0;
    tick.gimbal_relaxed    <= 1'b0;
    tick.auto_aim          <= 1'b0;
    tick.auto_fire_request <= 1'b0;
    tick.barrel_heat       <= '0;
    cfg.valid              <= 1'b0;
    cfg.index              <= CFG_SHOT_STEP;
    cfg.data               <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    ticks_sent     = 0;
    settings_used  = 1;   // reset values count as the first setting
    sb = new();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values, no idling on either side
    run_directed();
    clock_ms  = 32'd1200;
    enc_cur   = 32'h0000_0001;
    lever_cur = LEVER_DOWN;
    random_ticks(300);

    // high extremes: max step and heat limit, zero threshold, timeout, interval
    program_regs(20'hFFFFF, 20'h00000, 20'h00000, 20'h0FFFF, 20'h00000);
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    random_ticks(350);

    // opposite corner: zero step and heat limit, everything else at max
    program_regs(20'h00000, 20'hFFFFF, 20'h0FFFF, 20'h00000, 20'h0FFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    random_ticks(350);

    // moderate random setting
    program_regs(CFG_DAT_W'($urandom_range(1000, 100000)),
                 CFG_DAT_W'($urandom_range(100, 20000)),
                 CFG_DAT_W'($urandom_range(20, 2000)), CFG_DAT_W'($urandom_range(0, 200)),
                 CFG_DAT_W'($urandom_range(0, 800)));
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    random_ticks(350);

    // reset values again; upper data bits on the 16-bit registers are dropped
    program_regs(20'd49152, 20'd5000, 20'hF03E8, 20'hA0064, 20'h501F4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_ticks(350);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d ticks under %0d register settings, %0d results checked",
             ticks_sent, settings_used, sb.checked);
    $display("predicted %0d shots fired and %0d jams", sb.shots, sb.jams);
    if (sb.mismatches == 0) begin
      $display("shot_sequencer_jam_detect: match");
    end else begin
      $display("%0d result errors", sb.mismatches);
      $display("shot_sequencer_jam_detect: mismatch");
    end
    $finish;
  end

endmodule
